// File: src/assert_macros.svh
// Assertion macros used by rrp_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RRP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RRP_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define RRP_ASSERT(lbl, clk, rstn, prop, msg)
`define RRP_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: src/rrp_pkg.sv
// ---------------------------------------------------------------------------
// rrp_pkg
// Types and constants of the raster row PackBits packetizer.
// ---------------------------------------------------------------------------
package rrp_pkg;

    localparam int ROW_BYTES = 8192;
    localparam int ADDR_W    = $clog2(ROW_BYTES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int MAX_RUN   = 128;
    localparam int RUN_W     = $clog2(MAX_RUN) + 1;
    localparam int TOT_W     = 15;
    localparam int BODY_W    = 16;
    localparam int POS_W     = 16;
    localparam int NDIG      = 5;
    localparam int COPY_W    = 4;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CTL_LIT_FULL = 8'd127;
    localparam logic [7:0] CTL_RUN_FULL = 8'h81;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LOAD_LAST,
        OP_FETCH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       present;
        logic       stream_last;
    } res_t;

    function automatic logic [TOT_W-1:0] dec_weight(input logic [2:0] idx);
        logic [TOT_W-1:0] w;
        case (idx)
            3'd0:    w = TOT_W'(10000);
            3'd1:    w = TOT_W'(1000);
            3'd2:    w = TOT_W'(100);
            3'd3:    w = TOT_W'(10);
            default: w = TOT_W'(1);
        endcase
        return w;
    endfunction

endpackage

// File: src/rrp_front.sv
// ---------------------------------------------------------------------------
// rrp_front
// Accepts input items, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module rrp_front import rrp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       s_tlast,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       in_item;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        in_item.data = s_tdata;
        if (s_tuser) begin
            in_item.op = OP_FETCH;
        end else if (s_tlast) begin
            in_item.op = OP_LOAD_LAST;
        end else begin
            in_item.op = OP_LOAD;
        end
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: src/rrp_back.sv
// ---------------------------------------------------------------------------
// rrp_back
// Row store, PackBits scanner, decimal length converter and packet emitter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrp_back import rrp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    input  logic [COPY_W-1:0] plane_copies,
    input  logic              res_ready,
    output logic              res_valid,
    output res_t              res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_ENC_FIN,
        ST_DIG_SETUP,
        ST_DIG,
        ST_ARM,
        ST_FETCH
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] row_mem [ROW_BYTES];
    logic [7:0] ctl_mem [ROW_BYTES];
    logic [7:0] row_q, ctl_q;

    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]  trim_reg, trim_next;
    logic [CNT_W-1:0]  ctl_cnt_reg, ctl_cnt_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  sa_reg, sa_next;
    logic              pv_reg, pv_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [RUN_W-1:0]  lit_reg, lit_next;
    logic [7:0]        rv_reg, rv_next;
    logic              chunk_reg, chunk_next;
    logic [TOT_W-1:0]  dv_reg, dv_next;
    logic [2:0]        wi_reg, wi_next;
    logic [3:0]        dc_reg, dc_next;
    logic [3:0]        dig_reg [NDIG];
    logic [3:0]        dig_next [NDIG];
    logic [2:0]        nd_reg, nd_next;
    logic [3:0]        hlen_reg, hlen_next;
    logic [BODY_W-1:0] body_reg, body_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [COPY_W-1:0] sent_reg, sent_next;
    logic [CNT_W-1:0]  cctl_reg, cctl_next;
    logic [CNT_W-1:0]  cdat_reg, cdat_next;
    logic [RUN_W-1:0]  left_reg, left_next;
    logic [RUN_W-1:0]  step_reg, step_next;

    logic              emit_en;
    logic [7:0]        emit_val;
    logic              row_we;
    logic [ADDR_W-1:0] row_ra;
    logic              enc;
    logic [TOT_W-1:0]  data_len;
    logic [COPY_W-1:0] copies_now;
    logic [7:0]        hdr_byte;
    logic [POS_W-1:0]  h_idx;
    logic [POS_W-1:0]  d_start;
    logic [2:0]        d_sel;
    logic              same;

    assign enc      = (total_reg != '0);
    assign data_len = enc ? total_reg : TOT_W'(1);
    assign row_we   = (state_reg == ST_IDLE) && q_valid && (q_item.op != OP_FETCH)
                      && !pend_reg && (load_cnt_reg < CNT_W'(ROW_BYTES));
    assign row_ra   = (state_reg == ST_ENC) ? sa_reg[ADDR_W-1:0] : cdat_reg[ADDR_W-1:0];

    always_comb begin
        if (plane_copies == '0) begin
            copies_now = COPY_W'(1);
        end else if (plane_copies > COPY_W'(8)) begin
            copies_now = COPY_W'(8);
        end else begin
            copies_now = plane_copies;
        end
    end

    // header byte after the length field
    always_comb begin
        h_idx   = pos_reg - POS_W'(4);
        d_start = enc ? POS_W'(5) : POS_W'(3);
        d_sel   = 3'(h_idx - d_start);
        if (h_idx == POS_W'(0)) begin
            hdr_byte = CH_ESC;
        end else if (h_idx == POS_W'(1)) begin
            hdr_byte = CH_STAR;
        end else if (h_idx == POS_W'(2)) begin
            hdr_byte = CH_B;
        end else if (enc && h_idx == POS_W'(3)) begin
            hdr_byte = CH_TWO;
        end else if (enc && h_idx == POS_W'(4)) begin
            hdr_byte = CH_M;
        end else if (h_idx < d_start + POS_W'(nd_reg)) begin
            hdr_byte = CH_ZERO + 8'(dig_reg[d_sel]);
        end else begin
            hdr_byte = CH_W;
        end
    end

    // PackBits run tracking, at most one control per cycle
    always_comb begin
        emit_en    = 1'b0;
        emit_val   = '0;
        run_next   = run_reg;
        lit_next   = lit_reg;
        rv_next    = rv_reg;
        chunk_next = chunk_reg;
        same       = (run_reg != '0 || chunk_reg) && (row_q == rv_reg);
        if (state_reg == ST_ENC && pv_reg) begin
            if (same) begin
                if (run_reg == RUN_W'(1) && !chunk_reg && lit_reg != '0) begin
                    emit_en  = 1'b1;
                    emit_val = 8'(lit_reg - RUN_W'(1));
                    lit_next = '0;
                end
                if (run_reg == RUN_W'(MAX_RUN - 1)) begin
                    emit_en    = 1'b1;
                    emit_val   = CTL_RUN_FULL;
                    run_next   = '0;
                    chunk_next = 1'b1;
                end else begin
                    run_next = run_reg + RUN_W'(1);
                end
            end else begin
                if (run_reg >= RUN_W'(2) || (chunk_reg && run_reg != '0)) begin
                    emit_en  = 1'b1;
                    emit_val = 8'(9'd257 - 9'(run_reg));
                end else if (run_reg == RUN_W'(1)) begin
                    if (lit_reg == RUN_W'(MAX_RUN - 1)) begin
                        emit_en  = 1'b1;
                        emit_val = CTL_LIT_FULL;
                        lit_next = '0;
                    end else begin
                        lit_next = lit_reg + RUN_W'(1);
                    end
                end
                run_next   = RUN_W'(1);
                rv_next    = row_q;
                chunk_next = 1'b0;
            end
        end else if (state_reg == ST_ENC_FIN) begin
            if (run_reg >= RUN_W'(2) || (chunk_reg && run_reg != '0)) begin
                emit_en  = 1'b1;
                emit_val = 8'(9'd257 - 9'(run_reg));
            end else if (run_reg == RUN_W'(1)) begin
                emit_en  = 1'b1;
                emit_val = 8'(lit_reg);
            end
            run_next   = '0;
            lit_next   = '0;
            chunk_next = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        trim_next     = trim_reg;
        ctl_cnt_next  = ctl_cnt_reg;
        total_next    = total_reg;
        pend_next     = pend_reg;
        sa_next       = sa_reg;
        pv_next       = 1'b0;
        dv_next       = dv_reg;
        wi_next       = wi_reg;
        dc_next       = dc_reg;
        dig_next      = dig_reg;
        nd_next       = nd_reg;
        hlen_next     = hlen_reg;
        body_next     = body_reg;
        pos_next      = pos_reg;
        sent_next     = sent_reg;
        cctl_next     = cctl_reg;
        cdat_next     = cdat_reg;
        left_next     = left_reg;
        step_next     = step_reg;
        q_pop         = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        if (emit_en && ctl_cnt_reg < CNT_W'(ROW_BYTES)) begin
            ctl_cnt_next = ctl_cnt_reg + CNT_W'(1);
            total_next   = (emit_val <= CTL_LIT_FULL) ? total_reg + TOT_W'(emit_val) + TOT_W'(2)
                                                      : total_reg + TOT_W'(2);
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_item.op != OP_FETCH || res_ready)) begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_FETCH) begin
                        if (pend_reg) begin
                            state_next = ST_FETCH;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end else if (!pend_reg) begin
                        if (row_we) begin
                            load_cnt_next = load_cnt_reg + CNT_W'(1);
                            if (q_item.data != 8'd0) begin
                                trim_next = load_cnt_reg + CNT_W'(1);
                            end
                        end
                        if (q_item.op == OP_LOAD_LAST) begin
                            load_cnt_next = '0;
                            ctl_cnt_next  = '0;
                            total_next    = '0;
                            sa_next       = '0;
                            state_next    = ST_ENC;
                        end
                    end
                end
            end
            ST_ENC: begin
                if (sa_reg < trim_reg) begin
                    sa_next = sa_reg + CNT_W'(1);
                    pv_next = 1'b1;
                end else if (!pv_reg) begin
                    state_next = ST_ENC_FIN;
                end
            end
            ST_ENC_FIN: begin
                state_next = ST_DIG_SETUP;
            end
            ST_DIG_SETUP: begin
                dv_next    = data_len;
                wi_next    = '0;
                dc_next    = '0;
                nd_next    = '0;
                state_next = ST_DIG;
            end
            ST_DIG: begin
                if (dv_reg >= dec_weight(wi_reg)) begin
                    dv_next = dv_reg - dec_weight(wi_reg);
                    dc_next = dc_reg + 4'd1;
                end else begin
                    if (dc_reg != '0 || nd_reg != '0 || wi_reg == 3'(NDIG - 1)) begin
                        dig_next[nd_reg] = dc_reg;
                        nd_next = nd_reg + 3'd1;
                    end
                    dc_next = '0;
                    if (wi_reg == 3'(NDIG - 1)) begin
                        state_next = ST_ARM;
                    end else begin
                        wi_next = wi_reg + 3'd1;
                    end
                end
            end
            ST_ARM: begin
                hlen_next  = enc ? 4'd6 + 4'(nd_reg) : 4'd4 + 4'(nd_reg);
                body_next  = BODY_W'(hlen_next) + BODY_W'(data_len);
                trim_next  = '0;
                pend_next  = 1'b1;
                pos_next   = '0;
                sent_next  = '0;
                cctl_next  = '0;
                cdat_next  = '0;
                left_next  = '0;
                step_next  = RUN_W'(1);
                state_next = ST_IDLE;
            end
            ST_FETCH: begin
                res_valid   = 1'b1;
                res.present = 1'b1;
                if (pos_reg == POS_W'(0)) begin
                    res.out_byte = CH_ESC;
                end else if (pos_reg == POS_W'(1)) begin
                    res.out_byte = CH_T;
                end else if (pos_reg == POS_W'(2)) begin
                    res.out_byte = body_reg[7:0];
                end else if (pos_reg == POS_W'(3)) begin
                    res.out_byte = body_reg[15:8];
                end else if (h_idx < POS_W'(hlen_reg)) begin
                    res.out_byte = hdr_byte;
                end else if (!enc) begin
                    res.out_byte = 8'd0;
                end else if (left_reg == '0) begin
                    res.out_byte = ctl_q;
                    cctl_next    = cctl_reg + CNT_W'(1);
                    if (ctl_q <= CTL_LIT_FULL) begin
                        left_next = RUN_W'(ctl_q) + RUN_W'(1);
                        step_next = RUN_W'(1);
                    end else begin
                        left_next = RUN_W'(1);
                        step_next = RUN_W'(9'd257 - 9'(ctl_q));
                    end
                end else begin
                    res.out_byte = row_q;
                    cdat_next    = cdat_reg + CNT_W'(step_reg);
                    left_next    = left_reg - RUN_W'(1);
                end
                pos_next = pos_reg + POS_W'(1);
                if (pos_next >= POS_W'(body_reg) + POS_W'(4)) begin
                    pos_next  = '0;
                    sent_next = sent_reg + COPY_W'(1);
                    cctl_next = '0;
                    cdat_next = '0;
                    left_next = '0;
                    step_next = RUN_W'(1);
                    if (sent_next >= copies_now) begin
                        res.stream_last = 1'b1;
                        pend_next       = 1'b0;
                        sent_next       = '0;
                    end
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            load_cnt_reg <= '0;
            trim_reg     <= '0;
            ctl_cnt_reg  <= '0;
            total_reg    <= '0;
            pend_reg     <= 1'b0;
            sa_reg       <= '0;
            pv_reg       <= 1'b0;
            run_reg      <= '0;
            lit_reg      <= '0;
            chunk_reg    <= 1'b0;
            pos_reg      <= '0;
            sent_reg     <= '0;
            cctl_reg     <= '0;
            cdat_reg     <= '0;
            left_reg     <= '0;
            step_reg     <= RUN_W'(1);
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            trim_reg     <= trim_next;
            ctl_cnt_reg  <= ctl_cnt_next;
            total_reg    <= total_next;
            pend_reg     <= pend_next;
            sa_reg       <= sa_next;
            pv_reg       <= pv_next;
            run_reg      <= run_next;
            lit_reg      <= lit_next;
            chunk_reg    <= chunk_next;
            pos_reg      <= pos_next;
            sent_reg     <= sent_next;
            cctl_reg     <= cctl_next;
            cdat_reg     <= cdat_next;
            left_reg     <= left_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rv_reg   <= rv_next;
        dv_reg   <= dv_next;
        wi_reg   <= wi_next;
        dc_reg   <= dc_next;
        dig_reg  <= dig_next;
        nd_reg   <= nd_next;
        hlen_reg <= hlen_next;
        body_reg <= body_next;
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[load_cnt_reg[ADDR_W-1:0]] <= q_item.data;
        end
        row_q <= row_mem[row_ra];
    end

    always_ff @(posedge aclk) begin
        if (emit_en && ctl_cnt_reg < CNT_W'(ROW_BYTES)) begin
            ctl_mem[ctl_cnt_reg[ADDR_W-1:0]] <= emit_val;
        end
        ctl_q <= ctl_mem[cctl_reg[ADDR_W-1:0]];
    end

    `RRP_NEVER(a_pend_while_enc, aclk, aresetn, pend_reg && (state_reg == ST_ENC || state_reg == ST_ENC_FIN || state_reg == ST_DIG), "row encoded while output pending")
    `RRP_ASSERT(a_res_slot_free, aclk, aresetn, res_valid |-> res_ready, "result with output slot full")
    `RRP_NEVER(a_ctl_bound, aclk, aresetn, ctl_cnt_reg > CNT_W'(ROW_BYTES), "control count past row size")
    `RRP_ASSERT(a_fetch_one_cycle, aclk, aresetn, state_reg == ST_FETCH |=> state_reg == ST_IDLE, "fetch did not complete")

endmodule

// File: src/raster_row_packbits_packetizer.sv
// ---------------------------------------------------------------------------
// raster_row_packbits_packetizer
// Loads a raster row, PackBits-encodes it and streams the printer packets.
// ---------------------------------------------------------------------------
// Loads arriving while a row is still being read out are dropped. The
// row_end load starts the encoder, which walks the trimmed row through the
// row memory read port at one byte per cycle and then converts the encoded
// length to decimal by repeated subtraction before the back end takes the
// next item. A fetch item is answered from the fetch state, after the
// registered memory read, when a row is pending; a fetch right behind
// another waits for the result register to drain. The input queue holds two
// items and the result register holds one; an output stall holds back fetch
// items and so can fill the input queue. No clearing pass runs after reset.
module raster_row_packbits_packetizer import rrp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] raster_byte
    input  logic              s_tuser,   // [0] cmd
    input  logic              s_tlast,   // row_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tuser,   // [0] present
    output logic              m_tlast,   // stream_last
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COPY_W-1:0] cfg_data
);

    logic              q_valid;
    item_t             q_item;
    logic              q_pop;
    logic              res_valid;
    res_t              res;
    logic [COPY_W-1:0] copies_reg;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg.out_byte;
    assign m_tuser   = out_reg.present;
    assign m_tlast   = out_reg.stream_last;

    rrp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rrp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .plane_copies (copies_reg),
        .res_ready    (!out_valid_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copies_reg    <= COPY_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                copies_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives raster rows and fetch items into the PackBits packetizer and checks
// every output item against a cycle-free predictor of the packet stream,
// under random idling on both sides, long output stalls and copy settings.
// ---------------------------------------------------------------------------
module tb_top;
    import rrp_pkg::*;

    localparam bit CMD_LOAD  = 1'b0;
    localparam bit CMD_FETCH = 1'b1;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 750;

    typedef struct {
        logic [7:0] out_byte;
        logic       present;
        logic       stream_last;
    } stream_item_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;    // [7:0] raster_byte
    logic              s_tuser = 1'b0;  // [0] cmd
    logic              s_tlast = 1'b0;  // row_end
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // [7:0] out_byte
    logic              m_tuser;         // [0] present
    logic              m_tlast;         // stream_last
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [COPY_W-1:0] cfg_data = '0;

    raster_row_packbits_packetizer u_top (.*);

    always #2 aclk = ~aclk;

    // Predictor state
    logic [7:0]        row_mem [ROW_BYTES];
    logic [7:0]        ctl_mem [ROW_BYTES];
    logic [7:0]        hdr [16];
    logic [COPY_W-1:0] copies_reg = 4'd1;
    int unsigned ld_cnt, trim_len, n_ctl, enc_total, emit_pos, copies_done;
    int unsigned hdr_len, body_len, pay_len, ctl_ptr, dat_ptr, run_left, stride;
    bit busy_out;

    stream_item_t stream_q[$];
    int  errors, n_sent, n_checked, n_rows, cycles;
    bit  tx_idle_on, rx_idle_on;
    int  hold_reqs, hold_seen;
    int  hold_left, rx_gap;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("mismatch %0s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    task automatic add_ctl(input int unsigned v);
        if (n_ctl < ROW_BYTES) begin
            ctl_mem[n_ctl] = v[7:0];
            n_ctl++;
        end
    endtask

    task automatic pack_row();
        int unsigned len, i, j, n, k, tot, nd, v;
        logic [7:0] dig [8];
        len = trim_len; i = 0; tot = 0; nd = 0; n_ctl = 0;
        while (i < len) begin
            j = i + 1;
            while (j < len && row_mem[j] == row_mem[i]) j++;
            n = j - i;
            if (n >= 2) begin
                while (n >= MAX_RUN) begin
                    add_ctl(256 - (MAX_RUN - 1));
                    n -= MAX_RUN;
                end
                if (n != 0) add_ctl((256 - (n - 1)) & 255);
                i = j;
            end else begin
                j = i + 1;
                while (j < len && row_mem[j] != row_mem[j-1]) j++;
                k = (j < len) ? j - 1 : len;
                n = k - i;
                while (n >= MAX_RUN) begin
                    add_ctl(MAX_RUN - 1);
                    n -= MAX_RUN;
                end
                if (n != 0) add_ctl(n - 1);
                i = k;
            end
        end
        for (k = 0; k < n_ctl; k++)
            tot += (ctl_mem[k] <= CTL_LIT_FULL) ? ctl_mem[k] + 2 : 2;
        enc_total = tot & 32'h7FFF;
        pay_len = (enc_total != 0) ? enc_total : 1;
        v = pay_len;
        do begin
            dig[nd] = CH_ZERO + 8'(v % 10);
            nd++;
            v /= 10;
        end while (v != 0 && nd < 8);
        hdr_len = 0;
        hdr[hdr_len++] = CH_ESC;
        hdr[hdr_len++] = CH_STAR;
        hdr[hdr_len++] = CH_B;
        if (enc_total != 0) begin
            hdr[hdr_len++] = CH_TWO;
            hdr[hdr_len++] = CH_M;
        end
        while (nd != 0) begin
            nd--;
            hdr[hdr_len++] = dig[nd];
        end
        hdr[hdr_len++] = CH_W;
        body_len = hdr_len + pay_len;
    endtask

    task automatic next_payload_byte(output logic [7:0] v);
        if (enc_total == 0) begin
            v = 8'd0;
        end else if (run_left == 0) begin
            v = (ctl_ptr < n_ctl) ? ctl_mem[ctl_ptr] : 8'd0;
            ctl_ptr++;
            if (v <= CTL_LIT_FULL) begin
                run_left = v + 1; stride = 1;
            end else begin
                run_left = 1; stride = 257 - v;
            end
        end else begin
            v = (dat_ptr < ROW_BYTES) ? row_mem[dat_ptr] : 8'd0;
            dat_ptr += stride;
            run_left--;
        end
    endtask

    // Advance the predictor by one accepted input item.
    task automatic apply_item(input bit cmd, input logic [7:0] d, input bit last);
        int unsigned p, eff;
        logic [7:0] b;
        stream_item_t r;
        if (cmd == CMD_LOAD) begin
            if (busy_out) return;
            if (ld_cnt < ROW_BYTES) begin
                row_mem[ld_cnt] = d;
                ld_cnt++;
                if (d != 0) trim_len = ld_cnt;
            end
            if (last) begin
                pack_row();
                ld_cnt = 0; trim_len = 0; emit_pos = 0; copies_done = 0;
                ctl_ptr = 0; dat_ptr = 0; run_left = 0; stride = 1;
                busy_out = 1;
            end
            return;
        end
        r.out_byte = 8'd0; r.present = 1'b0; r.stream_last = 1'b0;
        if (busy_out) begin
            p = emit_pos;
            if (p == 0) b = CH_ESC;
            else if (p == 1) b = CH_T;
            else if (p == 2) b = body_len[7:0];
            else if (p == 3) b = body_len[15:8];
            else if (p - 4 < hdr_len) b = hdr[(p - 4) & 15];
            else next_payload_byte(b);
            p++;
            if (p >= 4 + body_len) begin
                p = 0;
                copies_done++;
                ctl_ptr = 0; dat_ptr = 0; run_left = 0; stride = 1;
                eff = (copies_reg == 0) ? 1 : (copies_reg > 8) ? 8 : copies_reg;
                if (copies_done >= eff) begin
                    r.stream_last = 1'b1;
                    busy_out = 0;
                    copies_done = 0;
                end
            end
            emit_pos = p & 16'hFFFF;
            r.out_byte = b;
            r.present = 1'b1;
        end
        stream_q.push_back(r);
    endtask

    task automatic send_item(input bit cmd, input logic [7:0] d, input bit last);
        int gap;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        apply_item(cmd, d, last);
        n_sent++;
    endtask

    task automatic fetch();
        send_item(CMD_FETCH, 8'($urandom), 1'($urandom));
    endtask

    task automatic drain_row();
        while (busy_out) fetch();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stream_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_copies(input logic [COPY_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        copies_reg = v;
        cfg_valid <= 1'b0;
    endtask

    // Load a row built from repeat runs and literal stretches, ending with
    // an optional zero tail, or an all-zero row.
    task automatic send_row(input int len, input bit all_zero, input bit zero_tail);
        logic [7:0] val;
        int i, seg, tail, lim;
        tail = zero_tail ? $urandom_range(1, 4) : 0;
        lim = ($urandom_range(0, 9) == 0) ? 140 : 12;
        i = 0;
        while (i < len) begin
            seg = $urandom_range(1, lim);
            val = 8'($urandom);
            for (int k = 0; k < seg && i < len; k++) begin
                if (all_zero || i >= len - tail) val = 8'd0;
                else if ($urandom_range(0, 1) == 0 && seg < 4) val = 8'($urandom);
                send_item(CMD_LOAD, val, i == len - 1);
                i++;
            end
        end
        n_rows++;
    endtask

    // Check results and pace the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (stream_q.size() == 0) begin
                $display("unexpected output item at %0t", $realtime);
                errors++;
            end else begin
                stream_item_t e;
                e = stream_q.pop_front();
                if (m_tdata !== e.out_byte) report_mismatch("out_byte", e.out_byte, m_tdata);
                if (m_tuser !== e.present) report_mismatch("present", e.present, m_tuser);
                if (m_tlast !== e.stream_last)
                    report_mismatch("stream_last", e.stream_last, m_tlast);
                n_checked++;
            end
        end
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic test_directed();
        fetch();                           // nothing pending
        send_item(CMD_LOAD, 8'h00, 1'b0);
        send_item(CMD_LOAD, 8'hFF, 1'b0);
        send_item(CMD_LOAD, 8'hFF, 1'b0);
        send_item(CMD_LOAD, 8'h01, 1'b0);
        send_item(CMD_LOAD, 8'h00, 1'b1);  // trailing zero trimmed
        fetch();
        send_item(CMD_LOAD, 8'hAA, 1'b1);  // ignored while output pending
        drain_row();
        fetch();
        send_item(CMD_LOAD, 8'h00, 1'b0);  // all-white row
        send_item(CMD_LOAD, 8'h00, 1'b1);
        drain_row();
        send_item(CMD_LOAD, 8'h80, 1'b1);  // one-byte row
        drain_row();
    endtask

    task automatic test_copies();
        logic [COPY_W-1:0] setting [3] = '{4'd0, 4'd15, 4'd2};
        foreach (setting[i]) begin
            write_copies(setting[i]);
            send_row(1, 1'b1, 1'b0);
            drain_row();
        end
        write_copies(4'd1);
    endtask

    // Repeat run one byte past a full chunk, then a literal stretch one byte
    // past a full chunk, in one row.
    task automatic test_long_row();
        for (int i = 0; i < MAX_RUN + 1; i++)
            send_item(CMD_LOAD, 8'h55, 1'b0);
        for (int i = 0; i < MAX_RUN + 1; i++)
            send_item(CMD_LOAD, 8'(i * 2 + 1), i == MAX_RUN);
        drain_row();
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_reqs++;
        send_row(12, 1'b0, 1'b0);
        repeat (20) fetch();
        drain_row();
        wait_drained();
    endtask

    task automatic test_random();
        logic [COPY_W-1:0] pick;
        while (n_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                pick = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
                write_copies(pick);
            end
            if ($urandom_range(0, 9) == 0) fetch();
            send_row($urandom_range(1, 30), $urandom_range(0, 11) == 0,
                     $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 5) == 0)
                send_item(CMD_LOAD, 8'($urandom), 1'($urandom));
            drain_row();
            if (n_sent > ITEM_TARGET - 60) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
        end
    endtask

    initial begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        busy_out = 0;
        stride = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_copies();
        test_long_row();
        test_backpressure();
        test_random();
        s_tvalid <= 1'b0;
        while (stream_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d items over %0d rows, checked %0d output items",
                 n_sent, n_rows, n_checked);
        $display("copy settings 0, 1-3 and above 8, all-white, trimmed and full-chunk rows covered");
        if (errors == 0 && stream_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
